/* rtl/wsa_pkg.sv */
// ----------------------------------------------------------------------------
// wsa_pkg: shared types and constants for the weighted slot allocator
// Request/response payloads, widths, weight reset tables and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package wsa_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int COUNT_BITS  = 12;
    localparam int WEIGHT_W    = 8;
    localparam int SLOT_W      = 16;
    localparam int RAND_W      = 32;
    localparam int CLS_W       = $clog2(NUM_CLASSES);
    localparam int WT_W        = WEIGHT_W + $clog2(NUM_CLASSES);
    localparam int PROD_W      = SLOT_W + WEIGHT_W;
    localparam int TOTAL_W     = COUNT_BITS + $clog2(NUM_CLASSES);
    localparam int CFG_REGS    = 2 * NUM_CLASSES;
    localparam int CFG_ADDR_W  = $clog2(CFG_REGS);

    typedef logic [NUM_CLASSES-1:0][WEIGHT_W-1:0] t_weight_tbl;

    // entry 0 sits in the low byte
    localparam t_weight_tbl UNCHOKE_RESET = {8'd9, 8'd6, 8'd3, 8'd1};
    localparam t_weight_tbl CHOKE_RESET   = {8'd1, 8'd1, 8'd1, 8'd1};

    localparam logic ACT_UNCHOKE = 1'b0;
    localparam logic ACT_CHOKE   = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [COUNT_BITS-1:0] class0_count;
        logic [COUNT_BITS-1:0] class1_count;
        logic [COUNT_BITS-1:0] class2_count;
        logic [COUNT_BITS-1:0] class3_count;
        logic [SLOT_W-1:0]     slots_wanted;
        logic [RAND_W-1:0]     random_word;
    } t_req;

    typedef struct packed {
        logic [COUNT_BITS-1:0] class0_grant;
        logic [COUNT_BITS-1:0] class1_grant;
        logic [COUNT_BITS-1:0] class2_grant;
        logic [COUNT_BITS-1:0] class3_grant;
        logic [TOTAL_W-1:0]    total_grant;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_QDIV,
        S_MUL,
        S_APPLY,
        S_RDIV,
        S_RFIND,
        S_RGIVE,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

/* rtl/wsa_divider.sv */
// ----------------------------------------------------------------------------
// wsa_divider: shared restoring divider
// One quotient bit per cycle; quotient and remainder valid with o_done.
// ----------------------------------------------------------------------------
`default_nettype none

module wsa_divider #(
    parameter int DIVIDEND_W = wsa_pkg::RAND_W,
    parameter int DIVISOR_W  = wsa_pkg::WT_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [DIVIDEND_W-1:0]      o_quot,
    output logic [DIVISOR_W-1:0]       o_rem
);
    import wsa_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    always_comb begin
        w_shift = {r_rem, r_quot[DIVIDEND_W-1]};
        w_ge    = (w_shift >= {1'b0, i_divisor});
        w_diff  = w_shift - {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DIVIDEND_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quot <= {r_quot[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* rtl/weighted_slot_allocator.sv */
// ----------------------------------------------------------------------------
// weighted_slot_allocator: split a slot budget over four weighted classes
// Share rounds of (slots left / active weight) times class weight, capped at
// each class's count, then a round-robin remainder from a random start.
// ----------------------------------------------------------------------------
//
//   port group   direction  handshake                      payload
//   -----------  ---------  -----------------------------  ---------------------
//   request      in         i_in_valid / o_in_stall        i_in_req  (t_req)
//   response     out        o_out_valid / i_out_stall      o_out_rsp (t_rsp)
//   config       in         i_cfg_we (no wait)             i_cfg_addr, i_cfg_wdata
//
// Flow: one request at a time. After the accept, S_SUM sums the active weight.
// Each share round runs the shared divider on the slots left, then visits the
// classes in S_MUL and S_APPLY; there are at most NUM_CLASSES rounds. The
// remainder start runs the divider on the random word and walks the weights in
// S_RFIND, then S_RGIVE visits the classes round-robin and S_FIN finishes. A
// request with no slots or no active weight goes from S_CHECK straight to S_FIN.
// Reset: synchronous, active low; weights return to their reset tables.
// Stalls: the finished response sits in an output register, so a new request
// is accepted while it waits; a second result waits in S_FIN for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_slot_allocator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire wsa_pkg::t_req                  i_in_req,
    // response channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output wsa_pkg::t_rsp                       o_out_rsp,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [wsa_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [wsa_pkg::WEIGHT_W-1:0]   i_cfg_wdata
);
    import wsa_pkg::*;

    localparam logic [CLS_W-1:0] LAST_CLS = CLS_W'(NUM_CLASSES - 1);

    // configuration weight tables
    t_weight_tbl r_unchoke_w;
    t_weight_tbl r_choke_w;

    // sequencer state and per-request working registers
    t_state                r_state,   n_state;
    logic [COUNT_BITS-1:0] r_cnt   [NUM_CLASSES];
    logic [COUNT_BITS-1:0] n_cnt   [NUM_CLASSES];
    logic [WEIGHT_W-1:0]   r_w     [NUM_CLASSES];
    logic [WEIGHT_W-1:0]   n_w     [NUM_CLASSES];
    logic [COUNT_BITS-1:0] r_grant [NUM_CLASSES];
    logic [COUNT_BITS-1:0] n_grant [NUM_CLASSES];
    logic [SLOT_W-1:0]     r_left,    n_left;
    logic [WT_W-1:0]       r_wt,      n_wt;
    logic [RAND_W-1:0]     r_rnd,     n_rnd;
    logic [SLOT_W-1:0]     r_share,   n_share;
    logic [PROD_W-1:0]     r_prod,    n_prod;
    logic [CLS_W-1:0]      r_idx,     n_idx;
    logic [WT_W-1:0]       r_start,   n_start;
    t_rsp                  r_out,     n_out;
    logic                  r_out_valid, n_out_valid;

    // shared divider
    logic              w_div_start;
    logic [RAND_W-1:0] w_div_dividend;
    logic              w_div_done;
    logic [RAND_W-1:0] w_div_quot;
    logic [WT_W-1:0]   w_div_rem;

    // helpers for the current class
    logic                  w_active;
    logic [COUNT_BITS-1:0] w_need;
    logic [WEIGHT_W-1:0]   w_cur_w;
    logic [WEIGHT_W-1:0]   w_room;
    logic [SLOT_W-1:0]     w_u_rr;
    logic [COUNT_BITS-1:0] w_u_sh;
    logic [WT_W-1:0]       w_wt_sum;
    logic [TOTAL_W-1:0]    w_total;
    logic                  w_in_acc;
    logic                  w_over;

    wsa_divider #(
        .DIVIDEND_W (RAND_W),
        .DIVISOR_W  (WT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_wt),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // configuration writes; indexes past the two tables drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unchoke_w <= UNCHOKE_RESET;
            r_choke_w   <= CHOKE_RESET;
        end else if (i_cfg_we) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                if (i_cfg_addr == CFG_ADDR_W'(i)) begin
                    r_unchoke_w[i] <= i_cfg_wdata;
                end
                if (i_cfg_addr == CFG_ADDR_W'(i + NUM_CLASSES)) begin
                    r_choke_w[i] <= i_cfg_wdata;
                end
            end
        end
    end

    // per-class helpers: need, room and the capped amounts
    always_comb begin
        w_cur_w  = r_w[r_idx];
        w_active = (w_cur_w != '0) && (r_grant[r_idx] < r_cnt[r_idx]);
        w_need   = r_cnt[r_idx] - r_grant[r_idx];
        w_room   = w_cur_w - r_start[WEIGHT_W-1:0];
        // share round: cap the product at what the class still lacks
        w_u_sh   = (r_prod > PROD_W'(w_need)) ? w_need : r_prod[COUNT_BITS-1:0];
        // remainder: cap by slots left, need and the room in this weight slice
        w_u_rr   = (r_left > SLOT_W'(w_need)) ? SLOT_W'(w_need) : r_left;
        if (w_u_rr > SLOT_W'(w_room)) begin
            w_u_rr = SLOT_W'(w_room);
        end
    end

    // active weight and grant total
    always_comb begin
        w_wt_sum = '0;
        w_total  = '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (r_cnt[i] != '0) begin
                w_wt_sum = w_wt_sum + WT_W'(r_w[i]);
            end
            w_total = w_total + TOTAL_W'(r_grant[i]);
        end
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_w         = r_w;
        n_grant     = r_grant;
        n_left      = r_left;
        n_wt        = r_wt;
        n_rnd       = r_rnd;
        n_share     = r_share;
        n_prod      = r_prod;
        n_idx       = r_idx;
        n_start     = r_start;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        w_div_start    = 1'b0;
        w_div_dividend = RAND_W'(r_left);

        // drop the response once it is taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cnt[0] = i_in_req.class0_count;
                    n_cnt[1] = i_in_req.class1_count;
                    n_cnt[2] = i_in_req.class2_count;
                    n_cnt[3] = i_in_req.class3_count;
                    for (int i = 0; i < NUM_CLASSES; i++) begin
                        n_w[i]     = (i_in_req.action == ACT_CHOKE) ? r_choke_w[i]
                                                                    : r_unchoke_w[i];
                        n_grant[i] = '0;
                    end
                    n_left  = i_in_req.slots_wanted;
                    n_rnd   = i_in_req.random_word;
                    n_state = S_SUM;
                end
            end

            S_SUM: begin
                n_wt    = w_wt_sum;
                n_state = S_CHECK;
            end

            // decide: another share round, the remainder, or finish
            S_CHECK: begin
                n_idx = '0;
                if (r_wt != '0 && r_left >= SLOT_W'(r_wt)) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = RAND_W'(r_left);
                    n_state        = S_QDIV;
                end else if (r_wt != '0 && r_left != '0) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = r_rnd;
                    n_state        = S_RDIV;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_QDIV: begin
                if (w_div_done) begin
                    n_share = w_div_quot[SLOT_W-1:0];
                    n_state = S_MUL;
                end
            end

            S_MUL: begin
                if (w_active) begin
                    n_prod  = PROD_W'(r_share) * PROD_W'(w_cur_w);
                    n_state = S_APPLY;
                end else if (r_idx == LAST_CLS) begin
                    n_state = S_CHECK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_APPLY: begin
                n_left         = r_left - SLOT_W'(w_u_sh);
                n_grant[r_idx] = r_grant[r_idx] + w_u_sh;
                if (w_u_sh == w_need) begin
                    n_wt = r_wt - WT_W'(w_cur_w);
                end
                if (r_idx == LAST_CLS) begin
                    n_state = S_CHECK;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_MUL;
                end
            end

            S_RDIV: begin
                if (w_div_done) begin
                    n_start = w_div_rem;
                    n_state = S_RFIND;
                end
            end

            // walk the active weights to the class holding the start point
            S_RFIND: begin
                if (w_active && r_start < WT_W'(w_cur_w)) begin
                    n_state = S_RGIVE;
                end else begin
                    if (w_active) begin
                        n_start = r_start - WT_W'(w_cur_w);
                    end
                    if (r_idx == LAST_CLS) begin
                        n_idx   = '0;
                        n_state = S_RGIVE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            S_RGIVE: begin
                if (r_wt == '0 || r_left == '0) begin
                    n_state = S_FIN;
                end else begin
                    if (w_active) begin
                        n_start        = '0;
                        n_left         = r_left - w_u_rr;
                        n_grant[r_idx] = r_grant[r_idx] + w_u_rr[COUNT_BITS-1:0];
                        if (w_u_rr == SLOT_W'(w_need)) begin
                            n_wt = r_wt - WT_W'(w_cur_w);
                        end
                    end
                    n_idx = (r_idx == LAST_CLS) ? '0 : r_idx + 1'b1;
                end
            end

            // hold until the output register is free
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.class0_grant = r_grant[0];
                    n_out.class1_grant = r_grant[1];
                    n_out.class2_grant = r_grant[2];
                    n_out.class3_grant = r_grant[3];
                    n_out.total_grant  = w_total;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_w     <= n_w;
        r_grant <= n_grant;
        r_left  <= n_left;
        r_wt    <= n_wt;
        r_rnd   <= n_rnd;
        r_share <= n_share;
        r_prod  <= n_prod;
        r_idx   <= n_idx;
        r_start <= n_start;
        r_out   <= n_out;
    end

    // any class granted past its count
    always_comb begin
        w_over = 1'b0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (r_grant[i] > r_cnt[i]) begin
                w_over = 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // the divider is never started on an empty weight total
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> (r_wt != '0))
        else $error("divider started with zero active weight");

    // a share round only runs with a share of at least one
    a_share_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QDIV && w_div_done) |-> (w_div_quot != '0))
        else $error("share round with zero share");

    // grants never pass the class counts in S_RGIVE and S_FIN
    a_grant_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RGIVE || r_state == S_FIN) |-> !w_over)
        else $error("class grant exceeds its count");

    // a loaded response carries the sum of its grants
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && n_state == S_IDLE) |=>
            (o_out_rsp.total_grant == TOTAL_W'(o_out_rsp.class0_grant)
                + TOTAL_W'(o_out_rsp.class1_grant) + TOTAL_W'(o_out_rsp.class2_grant)
                + TOTAL_W'(o_out_rsp.class3_grant)))
        else $error("total grant does not match class grants");
`endif

endmodule

`default_nettype wire

/* bench/weighted_slot_allocator_tb.sv */
// ----------------------------------------------------------------------------
// weighted_slot_allocator_tb: self-checking bench for the weighted slot allocator
// Drives requests under random idling and response stalls, predicts the grant per
// class for each accepted request and compares every response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_slot_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wsa_pkg::*;

    // register map: unchoke weights first, choke weights after them
    localparam int UNCHOKE_BASE = 0;
    localparam int CHOKE_BASE   = NUM_CLASSES;
    localparam int PHASE_REQS   = 292;

    // ------------------------------------------------------------------------
    // Grant scoreboard: holds its own copy of both weight tables, predicts the
    // grants of each accepted request and checks responses in order.
    // ------------------------------------------------------------------------
    class grant_scoreboard;
        t_weight_tbl unchoke_w;
        t_weight_tbl choke_w;
        t_rsp        grant_q[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            unchoke_w  = UNCHOKE_RESET;
            choke_w    = CHOKE_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void note_weight(int idx, logic [WEIGHT_W-1:0] val);
            if (idx < CHOKE_BASE)
                unchoke_w[idx - UNCHOKE_BASE] = val;
            else
                choke_w[idx - CHOKE_BASE] = val;
        endfunction

        function int pending();
            return grant_q.size();
        endfunction

        function t_rsp predict_grants(t_req r);
            int unsigned w[NUM_CLASSES];
            int unsigned cnt[NUM_CLASSES];
            int unsigned g[NUM_CLASSES];
            int unsigned left, wt, share, u, start, tot;
            int          pos, i;
            bit          found;
            t_rsp        rsp;
            cnt[0] = r.class0_count;
            cnt[1] = r.class1_count;
            cnt[2] = r.class2_count;
            cnt[3] = r.class3_count;
            left   = r.slots_wanted;
            wt     = 0;
            tot    = 0;
            for (i = 0; i < NUM_CLASSES; i++) begin
                w[i] = (r.action == ACT_CHOKE) ? choke_w[i] : unchoke_w[i];
                g[i] = 0;
                if (cnt[i] != 0)
                    wt += w[i];
            end
            // share rounds: a class that fills up drops out of the weight total
            while (wt != 0 && left / wt > 0) begin
                share = left / wt;
                for (i = 0; i < NUM_CLASSES; i++) begin
                    if (w[i] != 0 && g[i] < cnt[i]) begin
                        u = share * w[i];
                        if (u > cnt[i] - g[i])
                            u = cnt[i] - g[i];
                        left -= u;
                        g[i] += u;
                        if (g[i] >= cnt[i])
                            wt -= w[i];
                    end
                end
            end
            // remainder: walk the active weights to the random start, then go round
            if (wt != 0 && left != 0) begin
                start = r.random_word % wt;
                pos   = 0;
                found = 1'b0;
                for (i = 0; i < NUM_CLASSES; i++) begin
                    if (!found && w[i] != 0 && g[i] < cnt[i]) begin
                        if (start < w[i]) begin
                            pos   = i;
                            found = 1'b1;
                        end else begin
                            start -= w[i];
                        end
                    end
                end
                while (wt != 0 && left != 0) begin
                    if (w[pos] != 0 && g[pos] < cnt[pos]) begin
                        u = left;
                        if (u > cnt[pos] - g[pos])
                            u = cnt[pos] - g[pos];
                        if (u > w[pos] - start)
                            u = w[pos] - start;
                        start   = 0;
                        left   -= u;
                        g[pos] += u;
                        if (g[pos] >= cnt[pos])
                            wt -= w[pos];
                    end
                    pos = (pos + 1) % NUM_CLASSES;
                end
            end
            for (i = 0; i < NUM_CLASSES; i++)
                tot += g[i];
            rsp.class0_grant = COUNT_BITS'(g[0]);
            rsp.class1_grant = COUNT_BITS'(g[1]);
            rsp.class2_grant = COUNT_BITS'(g[2]);
            rsp.class3_grant = COUNT_BITS'(g[3]);
            rsp.total_grant  = TOTAL_W'(tot);
            return rsp;
        endfunction

        function void note_request(t_req r);
            grant_q.insert(grant_q.size(), predict_grants(r));
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_grant(t_rsp got);
            t_rsp want;
            if (grant_q.size() == 0) begin
                $display("%0t: response with none expected, expected nothing, got %p",
                         $time, got);
                mismatches++;
                return;
            end
            want = grant_q.pop_front();
            checked++;
            field_check("class0_grant", want.class0_grant, got.class0_grant);
            field_check("class1_grant", want.class1_grant, got.class1_grant);
            field_check("class2_grant", want.class2_grant, got.class2_grant);
            field_check("class3_grant", want.class3_grant, got.class3_grant);
            field_check("total_grant",  want.total_grant,  got.total_grant);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its stimulus signals
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_req                  i_in_req;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_rsp                  o_out_rsp;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [WEIGHT_W-1:0]   i_cfg_wdata;

    grant_scoreboard sb;
    logic            idle_on;
    int unsigned     weight_sets;
    int unsigned     choke_reqs;

    weighted_slot_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Response side: check what was accepted at this edge, then pick the stall
    // for the next one. Inputs are sampled before the edge updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_grant(o_out_rsp);
        i_out_stall <= idle_on && ($urandom_range(99) < 30);
    end

    // Hold the request until the block takes it; then note it for prediction
    // and, now and then, drop valid for a few cycles.
    task automatic send_req(input t_req r);
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        if (r.action == ACT_CHOKE)
            choke_reqs++;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_request(r);
        if (idle_on && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every predicted response has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both weight tables; call only while the block is idle.
    task automatic load_weights(input t_weight_tbl unch, input t_weight_tbl chk);
        int i;
        for (i = 0; i < 2 * NUM_CLASSES; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= CFG_ADDR_W'(i);
            i_cfg_wdata <= (i < CHOKE_BASE) ? unch[i - UNCHOKE_BASE] : chk[i - CHOKE_BASE];
            @(posedge i_clk);
            sb.note_weight(i, (i < CHOKE_BASE) ? unch[i - UNCHOKE_BASE] : chk[i - CHOKE_BASE]);
        end
        i_cfg_we <= 1'b0;
        weight_sets++;
    endtask

    function automatic t_req mk_req(logic act, int c0, int c1, int c2, int c3,
                                    int slots, logic [RAND_W-1:0] rnd);
        t_req r;
        r.action       = act;
        r.class0_count = COUNT_BITS'(c0);
        r.class1_count = COUNT_BITS'(c1);
        r.class2_count = COUNT_BITS'(c2);
        r.class3_count = COUNT_BITS'(c3);
        r.slots_wanted = SLOT_W'(slots);
        r.random_word  = rnd;
        return r;
    endfunction

    // Mostly small and empty classes so that caps, drop-outs and the remainder
    // all show up; full-width values keep every bit toggling.
    function automatic logic [COUNT_BITS-1:0] rand_count();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 25)      return '0;
        else if (sel < 60) return COUNT_BITS'($urandom_range(1, 15));
        else if (sel < 85) return COUNT_BITS'($urandom_range(1, 300));
        else               return COUNT_BITS'($urandom);
    endfunction

    function automatic t_req rand_req();
        int unsigned sel;
        t_req        r;
        sel            = $urandom_range(99);
        r.action       = ($urandom_range(1) == 1) ? ACT_CHOKE : ACT_UNCHOKE;
        r.class0_count = rand_count();
        r.class1_count = rand_count();
        r.class2_count = rand_count();
        r.class3_count = rand_count();
        if (sel < 20)      r.slots_wanted = SLOT_W'($urandom_range(0, 15));
        else if (sel < 60) r.slots_wanted = SLOT_W'($urandom_range(0, 500));
        else if (sel < 85) r.slots_wanted = SLOT_W'($urandom_range(0, 4000));
        else               r.slots_wanted = SLOT_W'($urandom);
        r.random_word  = $urandom;
        return r;
    endfunction

    // zero_pct of the entries are zero, the rest fall in lo..hi
    function automatic t_weight_tbl rand_tbl(int zero_pct, int lo, int hi);
        t_weight_tbl t;
        int          i;
        for (i = 0; i < NUM_CLASSES; i++)
            t[i] = ($urandom_range(99) < zero_pct) ? '0 : WEIGHT_W'($urandom_range(lo, hi));
        return t;
    endfunction

    task automatic random_phase(input t_weight_tbl unch, input t_weight_tbl chk);
        int n;
        load_weights(unch, chk);
        for (n = 0; n < PHASE_REQS; n++)
            send_req(rand_req());
        drain();
    endtask

    initial begin
        sb          = new();
        idle_on     = 1'b1;
        weight_sets = 0;
        choke_reqs  = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset weights: empty classes, full widths, overflow of slots,
        // zero slots, a single class and remainder starts across the weights.
        send_req(mk_req(ACT_UNCHOKE, 0, 0, 0, 0, 100, 32'd7));
        send_req(mk_req(ACT_UNCHOKE, 4095, 4095, 4095, 4095, 65535, 32'hFFFF_FFFF));
        send_req(mk_req(ACT_CHOKE, 4095, 4095, 4095, 4095, 65535, 32'hFFFF_FFFF));
        send_req(mk_req(ACT_UNCHOKE, 1, 2, 3, 4, 100, 32'd3));
        send_req(mk_req(ACT_UNCHOKE, 10, 10, 10, 10, 0, 32'd11));
        send_req(mk_req(ACT_UNCHOKE, 0, 0, 0, 4095, 1000, 32'd0));
        send_req(mk_req(ACT_UNCHOKE, 100, 100, 100, 100, 7, 32'd0));
        send_req(mk_req(ACT_UNCHOKE, 100, 100, 100, 100, 7, 32'd5));
        send_req(mk_req(ACT_UNCHOKE, 100, 100, 100, 100, 7, 32'd18));
        send_req(mk_req(ACT_UNCHOKE, 100, 100, 100, 100, 7, 32'd37));
        send_req(mk_req(ACT_CHOKE, 50, 50, 50, 50, 3, 32'd3));
        send_req(mk_req(ACT_UNCHOKE, 4095, 0, 1, 0, 65535, 32'h8000_0000));
        send_req(mk_req(ACT_CHOKE, 2, 0, 0, 1, 65535, 32'd1));
        drain();

        // Directed, zero weights: classes of weight zero get nothing, and with
        // only zero-weight classes populated nothing is granted at all.
        load_weights({8'd255, 8'd0, 8'd5, 8'd0}, '0);
        send_req(mk_req(ACT_UNCHOKE, 10, 10, 10, 10, 1000, 32'd9));
        send_req(mk_req(ACT_CHOKE, 10, 10, 10, 10, 1000, 32'd9));
        send_req(mk_req(ACT_UNCHOKE, 10, 0, 10, 0, 1000, 32'd2));
        send_req(mk_req(ACT_UNCHOKE, 4095, 4095, 4095, 4095, 65535, 32'h5A5A_A5A5));
        send_req(mk_req(ACT_UNCHOKE, 0, 300, 0, 40, 259, 32'd259));
        drain();

        // Random phases over several weight settings, extremes first.
        random_phase({NUM_CLASSES{8'd255}}, {NUM_CLASSES{8'd255}});
        random_phase('0, '0);
        random_phase(rand_tbl(25, 1, 255), rand_tbl(25, 1, 255));
        random_phase(rand_tbl(0, 1, 3), {8'd128, 8'd1, 8'd0, 8'd255});
        idle_on = 1'b0;         // hold both sides busy through a whole phase
        random_phase(rand_tbl(10, 0, 255), rand_tbl(10, 0, 255));
        idle_on = 1'b1;
        random_phase(rand_tbl(15, 1, 20), UNCHOKE_RESET);

        // let any stray response show up before the verdict
        repeat (500) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d responses never arrived", $time, sb.pending());
            sb.mismatches++;
        end
        $display("Checked %0d responses over %0d weight settings (%0d choke requests).",
                 sb.checked, weight_sets + 1, choke_reqs);
        if (sb.mismatches == 0)
            $display("PASS weighted_slot_allocator");
        else
            $display("FAIL weighted_slot_allocator");
        $finish;
    end

    // Run time limit, far beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("Timeout at %0t", $time);
        $display("FAIL weighted_slot_allocator");
        $finish;
    end

endmodule

`default_nettype wire
